FILE: rtl/core/fcds_pkg.sv
`default_nettype none
package fcds_pkg;

  // field and datapath widths
  localparam int TGT_W  = 27;
  localparam int SRC_W  = 29;
  localparam int CNT_W  = 7;
  localparam int DEN_W  = 6;
  localparam int N_W    = 29;
  localparam int FRAC_W = 24;
  localparam int ERR_W  = 31;
  localparam int DVD_W  = 53;
  localparam int DVS_W  = 42;
  localparam int IT_W   = 6;

  localparam int MAX_COUNT_DEF       = 64;
  localparam int MAX_DENOMINATOR_DEF = 63;

  localparam logic [SRC_W-1:0] SRC_RESET = SRC_W'(240000000);

  typedef struct packed {
    logic [TGT_W-1:0] target_hz;
  } req_t;

  typedef struct packed {
    logic [5:0]       clock_count_field;
    logic             clock_equals_source;
    logic [8:0]       integer_divider;
    logic [5:0]       frac_denominator;
    logic [5:0]       frac_numerator;
    logic [4:0]       fast_wait;
    logic [ERR_W-1:0] freq_error;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [IT_W-1:0]  iters;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/core/fcds_req_if.sv
`default_nettype none
interface fcds_req_if;
  import fcds_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fcds_res_if.sv
`default_nettype none
interface fcds_res_if;
  import fcds_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fractional_clock_divider_search.sv
// sequence: setup divisions, then per output count one ratio division and a loop over the
// denominators tried, each with its own frequency division
// throughput: one transaction at a time, set by the shared 1-bit-per-cycle divider
// request.ready is high only while idle; a finished result waits in the output register
// reset: synchronous, active high; source_clock_hz returns to 240000000
`default_nettype none
module fractional_clock_divider_search #(
  parameter int MAX_COUNT       = fcds_pkg::MAX_COUNT_DEF,
  parameter int MAX_DENOMINATOR = fcds_pkg::MAX_DENOMINATOR_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  fcds_req_if.sink                      request,
  fcds_res_if.source                    result,
  input  wire logic                     cfg_wr_en,
  input  wire logic [fcds_pkg::SRC_W-1:0] cfg_wr_data
);
  import fcds_pkg::*;

  // division lengths: each one shifts only the dividend bits it really has
  localparam logic [IT_W-1:0] IT_START = IT_W'(29);
  localparam logic [IT_W-1:0] IT_END   = IT_W'(21);
  localparam logic [IT_W-1:0] IT_FDIV  = IT_W'(53);
  localparam logic [IT_W-1:0] IT_FREQ  = IT_W'(35);
  localparam logic [29:0]     HALF     = 30'd8388608;

  typedef enum logic [4:0] {
    IDLE, START_GO, START_WAIT, END_GO, END_WAIT, CNT_CHECK, CT_MUL, FDIV_GO,
    FDIV_WAIT, DEN_CHECK, FA_MUL, B_CALC, DEN_MUL, Q_GO, Q_WAIT, COMPARE,
    FOLD, WAIT_MUL, DONE
  } state_t;

  state_t state;

  // configuration register
  logic [SRC_W-1:0] s;

  always_ff @(posedge clk) begin
    if (rst) begin
      s <= SRC_RESET;
    end else if (cfg_wr_en) begin
      s <= cfg_wr_data;
    end
  end

  // search registers
  logic [TGT_W-1:0]  t;
  logic [CNT_W-1:0]  top_cnt;
  logic [CNT_W-1:0]  end_cnt;
  logic [CNT_W-1:0]  cnt;
  logic [DEN_W-1:0]  a;
  logic [DEN_W-1:0]  b;
  logic [N_W-1:0]    n;
  logic [FRAC_W-1:0] frac;
  logic [33:0]       ct;
  logic [29:0]       fa;
  logic [34:0]       na;
  logic [34:0]       sa;
  logic [DVS_W-1:0]  den;
  logic [34:0]       freq;
  logic [36:0]       prod;

  // best candidate so far
  logic [ERR_W-1:0]  best_diff;
  logic [CNT_W-1:0]  best_cnt;
  logic [N_W:0]      best_n;
  logic [DEN_W-1:0]  best_a;
  logic [DEN_W-1:0]  best_b;

  logic res_valid;
  res_t res_data;

  div_req_t dreq;
  div_rsp_t drsp;

  fcds_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // divider requests, one per launch state
  always_comb begin
    dreq = '0;
    unique case (state)
      START_GO: begin
        // s / (2t)
        dreq.start    = 1'b1;
        dreq.iters    = IT_START;
        dreq.dividend = {s, 24'd0};
        dreq.divisor  = DVS_W'({t, 1'b0});
      end
      END_GO: begin
        // (s / 256) / t
        dreq.start    = 1'b1;
        dreq.iters    = IT_END;
        dreq.dividend = {s[SRC_W-1:8], 32'd0};
        dreq.divisor  = DVS_W'(t);
      end
      FDIV_GO: begin
        // fixed-point divider ratio with 24 fraction bits
        dreq.start    = 1'b1;
        dreq.iters    = IT_FDIV;
        dreq.dividend = {s, 24'd0};
        dreq.divisor  = DVS_W'(ct);
      end
      Q_GO: begin
        // frequency reached by this candidate
        dreq.start    = 1'b1;
        dreq.iters    = IT_FREQ;
        dreq.dividend = {sa, 18'd0};
        dreq.divisor  = den;
      end
      default: ;
    endcase
  end

  logic [DVD_W-1:0] q;
  logic [N_W-1:0]   fdiv_n;
  logic [CNT_W-1:0] end_sat;
  logic [29:0]      b_sum;
  logic [34:0]      t_ext;
  logic [34:0]      d;

  always_comb begin
    q      = drsp.quotient;
    fdiv_n = q[DVD_W-1:FRAC_W];
    // end bound saturates; anything above the count range ends the search anyway
    if (q[20:0] >= 21'd127) begin
      end_sat = '1;
    end else if (q[20:0] < 21'd2) begin
      end_sat = CNT_W'(2);
    end else begin
      end_sat = q[CNT_W-1:0];
    end
    if (top_cnt <= CNT_W'(2)) begin
      end_sat = CNT_W'(1);
    end
    b_sum = fa + HALF;
    t_ext = 35'(t);
    d     = (freq > t_ext) ? (freq - t_ext) : (t_ext - freq);
  end

  assign request.ready = (state == IDLE);
  assign result.valid  = res_valid;
  assign result.data   = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      res_valid <= 1'b0;
    end else begin
      // the final state reloads the output register itself
      if (result.valid && result.ready && state != DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (request.valid) begin
            // a zero target counts as 1 Hz
            t         <= (request.data.target_hz == '0) ? TGT_W'(1)
                                                        : request.data.target_hz;
            best_diff <= '1;
            best_cnt  <= CNT_W'(MAX_COUNT);
            best_n    <= (N_W + 1)'(256);
            best_a    <= DEN_W'(MAX_DENOMINATOR);
            best_b    <= DEN_W'(MAX_DENOMINATOR - 1);
            state     <= START_GO;
          end
        end
        START_GO: state <= START_WAIT;
        START_WAIT: begin
          if (drsp.done) begin
            top_cnt <= (q[28:0] >= 29'(MAX_COUNT)) ? CNT_W'(MAX_COUNT)
                                                   : q[CNT_W-1:0] + 1'b1;
            state   <= END_GO;
          end
        end
        END_GO: state <= END_WAIT;
        END_WAIT: begin
          if (drsp.done) begin
            end_cnt <= end_sat;
            cnt     <= top_cnt;
            state   <= CNT_CHECK;
          end
        end
        CNT_CHECK: begin
          if (best_diff != '0 && cnt >= end_cnt && cnt != '0) begin
            state <= CT_MUL;
          end else begin
            state <= FOLD;
          end
        end
        CT_MUL: begin
          ct    <= 34'(cnt) * 34'(t);
          state <= FDIV_GO;
        end
        FDIV_GO: state <= FDIV_WAIT;
        FDIV_WAIT: begin
          if (drsp.done) begin
            // n below 2 clamps to 2; the fraction is then negative and clamps to 0
            if (fdiv_n < N_W'(2)) begin
              n    <= N_W'(2);
              frac <= '0;
            end else begin
              n    <= fdiv_n;
              frac <= q[FRAC_W-1:0];
            end
            a     <= DEN_W'(MAX_DENOMINATOR);
            state <= DEN_CHECK;
          end
        end
        DEN_CHECK: begin
          if (best_diff == '0 || a == '0) begin
            cnt   <= cnt - 1'b1;
            state <= CNT_CHECK;
          end else begin
            state <= FA_MUL;
          end
        end
        FA_MUL: begin
          fa    <= 30'(frac) * 30'(a);
          state <= B_CALC;
        end
        B_CALC: begin
          // numerator rounds half up
          b     <= b_sum[29:24];
          na    <= 35'(n) * 35'(a);
          state <= DEN_MUL;
        end
        DEN_MUL: begin
          if (a == b && n == N_W'(256)) begin
            cnt   <= cnt - 1'b1;
            state <= CNT_CHECK;
          end else begin
            den   <= 42'(na + 35'(b)) * 42'(cnt);
            sa    <= 35'(s) * 35'(a);
            state <= Q_GO;
          end
        end
        Q_GO: state <= Q_WAIT;
        Q_WAIT: begin
          if (drsp.done) begin
            freq  <= q[34:0];
            state <= COMPARE;
          end
        end
        COMPARE: begin
          if (35'(best_diff) > d) begin
            best_diff <= d[ERR_W-1:0];
            best_cnt  <= cnt;
            best_n    <= (N_W + 1)'(n);
            best_a    <= a;
            best_b    <= b;
            if (b == '0 || a == b) begin
              cnt   <= cnt - 1'b1;
              state <= CNT_CHECK;
            end else begin
              a     <= a - 1'b1;
              state <= DEN_CHECK;
            end
          end else begin
            a     <= a - 1'b1;
            state <= DEN_CHECK;
          end
        end
        FOLD: begin
          // a whole fraction folds into the integer part
          if (best_a == best_b) begin
            best_b <= '0;
            best_n <= best_n + 1'b1;
          end
          state <= WAIT_MUL;
        end
        WAIT_MUL: begin
          prod  <= 37'(best_n) * 37'(best_cnt);
          state <= DONE;
        end
        DONE: begin
          if (!res_valid || result.ready) begin
            res_valid                    <= 1'b1;
            res_data.clock_count_field   <= (best_cnt > CNT_W'(2))
                                            ? 6'(best_cnt - 1'b1) : 6'd1;
            res_data.clock_equals_source <= (best_cnt == CNT_W'(1));
            res_data.integer_divider     <= best_n[8:0];
            res_data.frac_denominator    <= best_a;
            res_data.frac_numerator      <= best_b;
            res_data.fast_wait           <= (prod < 37'd24) ? 5'(37'd24 - prod) : 5'd0;
            res_data.freq_error          <= best_diff;
            state                        <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // divider results only arrive while the sequencer waits for them
  assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> (state == START_WAIT || state == END_WAIT ||
                   state == FDIV_WAIT || state == Q_WAIT))
    else $error("divider finished outside a wait state");

  // the best error never grows during the search
  assert property (@(posedge clk) disable iff (rst)
    state == COMPARE |=> best_diff <= $past(best_diff))
    else $error("best error increased");

  // a kept candidate always has a nonzero denominator
  assert property (@(posedge clk) disable iff (rst)
    state == FOLD |-> best_a != '0)
    else $error("zero denominator kept");

  // leaving the final state always presents a result transaction
  assert property (@(posedge clk) disable iff (rst)
    (state == DONE && (!res_valid || result.ready)) |=> result.valid)
    else $error("result not presented");

endmodule
`default_nettype wire

FILE: rtl/core/fcds_div.sv
`default_nettype none
module fcds_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire fcds_pkg::div_req_t  req,
  output fcds_pkg::div_rsp_t       rsp
);
  import fcds_pkg::*;

  logic             run;
  logic             done;
  logic [IT_W-1:0]  left;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   sh;
  logic             ge;
  logic [DVS_W-1:0] rem_next;

  // one quotient bit per cycle, restoring
  always_comb begin
    sh       = {rem, dvd[DVD_W-1]};
    ge       = sh >= {1'b0, dvs};
    rem_next = ge ? DVS_W'(sh - {1'b0, dvs}) : sh[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run  <= 1'b1;
        left <= req.iters;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (run) begin
        rem  <= rem_next;
        dvd  <= {dvd[DVD_W-2:0], ge};
        left <= left - 1'b1;
        if (left == IT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;
endmodule
`default_nettype wire

FILE: tb/sv/tb_fractional_clock_divider_search.sv
`default_nettype none

module tb_fractional_clock_divider_search;
  timeunit 1ns;
  timeprecision 1ps;
  import fcds_pkg::*;

  // golden search for the best fractional divider plus the queue of pending results
  class divider_scoreboard;
    longint unsigned   source_hz;
    res_t              pending_q[$];
    int unsigned       mismatches;
    int unsigned       failures;

    function new();
      source_hz   = 64'(SRC_RESET);
      mismatches  = 0;
      failures    = 0;
    endfunction

    function res_t search_divider(logic [TGT_W-1:0] target);
      longint unsigned s, t, diff, best_n, best_a, best_b, best_cnt;
      longint unsigned first_cnt, last_cnt, cnt, fdiv, n, whole, frac, a, b, den, freq, d;
      longint          wait_cnt;
      res_t            r;
      s        = source_hz;
      t        = 64'(target);
      diff     = 64'd2147483647;
      best_n   = 256;
      best_a   = MAX_DENOMINATOR_DEF;
      best_b   = MAX_DENOMINATOR_DEF - 1;
      best_cnt = MAX_COUNT_DEF;
      // a zero target counts as 1 Hz
      if (t == 0) t = 1;
      first_cnt = s / (2 * t) + 1;
      if (first_cnt > MAX_COUNT_DEF) first_cnt = MAX_COUNT_DEF;
      last_cnt = s / 256 / t;
      if (last_cnt < 2) last_cnt = 2;
      if (first_cnt <= 2) last_cnt = 1;
      for (cnt = first_cnt; diff != 0 && cnt >= last_cnt && cnt > 0; cnt--) begin
        fdiv  = (s << FRAC_W) / (cnt * t);
        n     = fdiv >> FRAC_W;
        if (n < 2) n = 2;
        whole = n << FRAC_W;
        // negative fraction clamps to zero
        frac  = (fdiv > whole) ? fdiv - whole : 0;
        for (a = MAX_DENOMINATOR_DEF; diff != 0 && a > 0; a--) begin
          b = (frac * a + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
          if (a == b && n == 256) break;
          den  = n * cnt * a + b * cnt;
          freq = (s * a) / den;
          d    = (t > freq) ? t - freq : freq - t;
          if (diff <= d) continue;
          diff     = d;
          best_cnt = cnt;
          best_n   = n;
          best_b   = b;
          best_a   = a;
          if (b == 0 || a == b) break;
        end
      end
      // full fraction folds into the integer part
      if (best_a == best_b) begin
        best_b = 0;
        best_n = best_n + 1;
      end
      wait_cnt = 24 - longint'(best_n * best_cnt);
      if (wait_cnt < 0) wait_cnt = 0;
      r.clock_count_field   = 6'((best_cnt > 2) ? best_cnt - 1 : 1);
      r.clock_equals_source = (best_cnt == 1);
      r.integer_divider     = 9'(best_n);
      r.frac_denominator    = 6'(best_a);
      r.frac_numerator      = 6'(best_b);
      r.fast_wait           = 5'(wait_cnt);
      r.freq_error          = ERR_W'(diff);
      return r;
    endfunction

    function void note_request(logic [TGT_W-1:0] target);
      pending_q.push_back(search_divider(target));
    endfunction

    function void check_result(res_t got);
      res_t want;
      bit   bad;
      if (pending_q.size() == 0) begin
        failures++;
        if (mismatches++ < 10) $display("unexpected result transaction %p", got);
        return;
      end
      want = pending_q.pop_front();
      bad  = (got.clock_count_field   !== want.clock_count_field)   ||
             (got.clock_equals_source !== want.clock_equals_source) ||
             (got.integer_divider     !== want.integer_divider)     ||
             (got.frac_denominator    !== want.frac_denominator)    ||
             (got.frac_numerator      !== want.frac_numerator)      ||
             (got.fast_wait           !== want.fast_wait)           ||
             (got.freq_error          !== want.freq_error);
      if (bad) begin
        failures++;
        if (mismatches++ < 10) $display("result mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [SRC_W-1:0] cfg_wr_data;

  fcds_req_if req_ch();
  fcds_res_if res_ch();

  divider_scoreboard sb;

  // asks the result side for one long hold-off
  bit          long_hold_req;
  int unsigned hold_left;
  int unsigned gap_left;

  fractional_clock_divider_search DUT (
    .clk         (clk),
    .rst         (rst),
    .request     (req_ch),
    .result      (res_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // everything known from time zero
  initial begin
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    res_ch.ready = 1'b0;
    sb           = new();
    long_hold_req = 1'b0;
  end

  // transaction monitors, sampled on the rising edge
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) sb.note_request(req_ch.data.target_hz);
    if (!rst && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
  end

  // result side back-pressure: mostly ready, short and long gaps, one very long hold-off
  initial begin
    hold_left = 0;
    gap_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        // long enough that the output register fills and input stalls
        long_hold_req = 1'b0;
        hold_left     = 40000;
        res_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        res_ch.ready <= 1'b0;
        gap_left--;
      end else begin
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          res_ch.ready <= 1'b1;
        end else if (roll < 95) begin
          res_ch.ready <= 1'b0;
          gap_left = $urandom_range(0, 3);
        end else begin
          res_ch.ready <= 1'b0;
          gap_left = $urandom_range(10, 60);
        end
      end
    end
  end

  // offer one target; valid stays up from the last transaction when there is no gap
  task automatic send_target(logic [TGT_W-1:0] target);
    int unsigned roll, gap;
    roll = $urandom_range(0, 99);
    if (roll < 40) gap = 0;
    else if (roll < 93) gap = $urandom_range(1, 4);
    else gap = $urandom_range(20, 80);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.data.target_hz <= target;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // stop offering and wait until every result has come back
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // register write, only between phases while the block is idle
  task automatic write_source(logic [SRC_W-1:0] hz);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hz;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.source_hz = 64'(hz);
  endtask

  // random target: mostly near the top where few counts are searched,
  // some tiny ones where the search range is short or empty
  function automatic logic [TGT_W-1:0] pick_target();
    longint unsigned s, lo, hi;
    s = sb.source_hz;
    if (s < 64) return TGT_W'($urandom());
    if ($urandom_range(0, 9) == 0) return TGT_W'($urandom_range(1, s / 16128 + 1));
    hi = s / 2;
    if (hi > 80000000) hi = 80000000;
    lo = s / 16 + 1;
    return TGT_W'($urandom_range(int'(lo), int'(hi)));
  endfunction

  task automatic random_burst(int unsigned count);
    repeat (count) send_target(pick_target());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed at the reset source clock: zero target, extremes, exact ratios,
    // a target at half the source, and ones that leave the count range empty
    send_target('0);
    send_target(TGT_W'(1));
    send_target(TGT_W'(80000000));
    send_target('1);
    send_target(TGT_W'(120000000));
    send_target(TGT_W'(60000000));
    send_target(TGT_W'(40000000));
    send_target(TGT_W'(33333333));
    send_target(TGT_W'(20000000));
    send_target(TGT_W'(10000000));
    send_target(TGT_W'(1000000));
    send_target(TGT_W'(14800));
    send_target(TGT_W'(100));

    // random with one long hold-off on the result side while targets keep coming
    long_hold_req = 1'b1;
    random_burst(20);
    drain();

    // slowest allowed source clock
    write_source(SRC_W'(1000000));
    send_target(TGT_W'(500000));
    send_target(TGT_W'(1));
    random_burst(14);
    drain();

    // fastest allowed source clock, reaches the top bits of the target
    write_source(SRC_W'(400000000));
    send_target(TGT_W'(80000000));
    send_target(TGT_W'(70000000));
    random_burst(18);
    drain();

    // stopped source clock
    write_source('0);
    send_target(TGT_W'(1));
    send_target('1);
    send_target(TGT_W'($urandom()));
    drain();

    // an arbitrary source clock in between
    write_source(SRC_W'($urandom_range(2000000, 399000000)));
    random_burst(16);
    drain();

    // back to the reset value
    write_source(SRC_RESET);
    random_burst(10);
    drain();

    repeat (200) @(posedge clk);
    if (sb.failures == 0) begin
      $display("fractional_clock_divider_search test passed");
    end else begin
      $display("fractional_clock_divider_search test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000000;
    $display("fractional_clock_divider_search test failed");
    $finish;
  end

endmodule

`default_nettype wire
